FILE: hdl/tdpe_pkg.sv
// shared types, codes and defaults of the trial division prime engine
package tdpe_pkg;

    localparam int unsigned NUMBER_WIDTH_DEF = 16;
    localparam int unsigned MAX_LISTED_DEF   = 64;

    // fixed field widths on the stream ports
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned OUT_USER_W = 2;

    // bit positions in the output tuser
    localparam int unsigned USER_PRIME = 0;
    localparam int unsigned USER_TRUNC = 1;

    // smallest prime, first candidate and first trial divisor
    localparam int unsigned SMALLEST_PRIME = 2;

    // mode codes carried in the input tuser
    localparam logic MODE_TEST = 1'b0;
    localparam logic MODE_LIST = 1'b1;

    typedef enum logic [1:0] {
        CK_IDLE,
        CK_TEST,
        CK_WAIT
    } t_chk_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST_WAIT,
        ST_LIST_NEXT,
        ST_LIST_WAIT,
        ST_PUT
    } t_top_state;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_stat;

    typedef struct packed {
        logic done;
        logic prime;
    } t_chk_stat;

endpackage

FILE: hdl/trial_division_prime_engine.sv
// top level of the trial division prime engine: mode control, list tracking, output register
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+-----------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: number, tuser: mode
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: value, tuser: is_prime, truncated,
//          |     |                               | tlast: last
//
//  each trial divisor runs through the bit-serial remainder unit; a candidate n tries
//  divisors 2 .. floor(sqrt(n)); test mode checks the one number, and list mode checks
//  every candidate below the bound, stopping early at the first prime past the list limit
//  reset is synchronous, active low, and clears the sequencers, the list pending flag and count,
//  and the output valid only; s_axis_tready is high only while the engine is idle; the result
//  register is free for a new item meanwhile, and a low m_axis_tready stalls listing at the next result to send
module trial_division_prime_engine
    import tdpe_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF,
    parameter int unsigned MAX_LISTED   = MAX_LISTED_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [FIELD_W-1:0]    s_axis_tdata,   // [15:0] number
    input  logic                  s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [FIELD_W-1:0]    m_axis_tdata,   // [15:0] value
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] is_prime, [1] truncated
    output logic                  m_axis_tlast    // last result of the item
);

    localparam int unsigned CNT_W = $clog2(MAX_LISTED + 1);

    // control sequencer
    t_top_state              r_state, n_state;
    logic [NUMBER_WIDTH-1:0] r_num, n_num;       // tested number or list bound
    logic [NUMBER_WIDTH-1:0] r_cand, n_cand;     // next list candidate
    logic [NUMBER_WIDTH-1:0] r_pend, n_pend;     // prime held back until its last flag is known
    logic                    r_pend_valid, n_pend_valid;
    logic [CNT_W-1:0]        r_count, n_count;   // primes found, pending one included

    // result waiting for the output register
    logic [NUMBER_WIDTH-1:0] r_res_value, n_res_value;
    logic                    r_res_prime, n_res_prime;
    logic                    r_res_last, n_res_last;
    logic                    r_res_trunc, n_res_trunc;
    logic                    r_res_final, n_res_final;

    // output register
    logic                    r_out_valid;
    logic [FIELD_W-1:0]      r_out_value;
    logic                    r_out_prime;
    logic                    r_out_last;
    logic                    r_out_trunc;

    logic                    w_accept;
    logic                    w_slot_free;
    logic                    w_put;
    logic                    w_chk_start;
    logic [NUMBER_WIDTH-1:0] w_chk_cand;
    t_chk_stat               w_chk_stat;

    tdpe_prime_chk #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_chk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_chk_start),
        .i_cand (w_chk_cand),
        .o_stat (w_chk_stat)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // output register can take a result this cycle
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_put         = (r_state == ST_PUT) && w_slot_free;

    always_comb begin
        n_state      = r_state;
        n_num        = r_num;
        n_cand       = r_cand;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_count      = r_count;
        n_res_value  = r_res_value;
        n_res_prime  = r_res_prime;
        n_res_last   = r_res_last;
        n_res_trunc  = r_res_trunc;
        n_res_final  = r_res_final;
        w_chk_start  = 1'b0;
        w_chk_cand   = r_cand;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_num = NUMBER_WIDTH'(s_axis_tdata);
                    if (s_axis_tuser == MODE_TEST) begin
                        w_chk_start = 1'b1;
                        w_chk_cand  = NUMBER_WIDTH'(s_axis_tdata);
                        n_state     = ST_TEST_WAIT;
                    end else begin
                        n_cand       = NUMBER_WIDTH'(SMALLEST_PRIME);
                        n_pend_valid = 1'b0;
                        n_count      = '0;
                        n_state      = ST_LIST_NEXT;
                    end
                end
            end
            ST_TEST_WAIT: begin
                if (w_chk_stat.done) begin
                    n_res_value = r_num;
                    n_res_prime = w_chk_stat.prime;
                    n_res_last  = 1'b1;
                    n_res_trunc = 1'b0;
                    n_res_final = 1'b1;
                    n_state     = ST_PUT;
                end
            end
            ST_LIST_NEXT: begin
                if (r_cand >= r_num) begin
                    // bound reached: close with the held prime, or an empty marker
                    n_res_value = r_pend_valid ? r_pend : '0;
                    n_res_prime = r_pend_valid;
                    n_res_last  = 1'b1;
                    n_res_trunc = 1'b0;
                    n_res_final = 1'b1;
                    n_state     = ST_PUT;
                end else begin
                    w_chk_start = 1'b1;
                    w_chk_cand  = r_cand;
                    n_state     = ST_LIST_WAIT;
                end
            end
            ST_LIST_WAIT: begin
                if (w_chk_stat.done) begin
                    n_cand = r_cand + NUMBER_WIDTH'(1);
                    if (!w_chk_stat.prime) begin
                        n_state = ST_LIST_NEXT;
                    end else if (r_pend_valid && (r_count == CNT_W'(MAX_LISTED))) begin
                        // another prime past the limit: list is cut short
                        n_res_value = r_pend;
                        n_res_prime = 1'b1;
                        n_res_last  = 1'b1;
                        n_res_trunc = 1'b1;
                        n_res_final = 1'b1;
                        n_state     = ST_PUT;
                    end else if (r_pend_valid) begin
                        n_res_value = r_pend;
                        n_res_prime = 1'b1;
                        n_res_last  = 1'b0;
                        n_res_trunc = 1'b0;
                        n_res_final = 1'b0;
                        n_pend      = r_cand;
                        n_count     = r_count + CNT_W'(1);
                        n_state     = ST_PUT;
                    end else begin
                        n_pend       = r_cand;
                        n_pend_valid = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_state      = ST_LIST_NEXT;
                    end
                end
            end
            ST_PUT: begin
                if (w_slot_free) begin
                    n_state = r_res_final ? ST_IDLE : ST_LIST_NEXT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_num        <= n_num;
            r_cand       <= n_cand;
            r_pend       <= n_pend;
            r_res_value  <= n_res_value;
            r_res_prime  <= n_res_prime;
            r_res_last   <= n_res_last;
            r_res_trunc  <= n_res_trunc;
            r_res_final  <= n_res_final;
        end
    end

    // output register, refilled in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
            r_out_value <= FIELD_W'(r_res_value);
            r_out_prime <= r_res_prime;
            r_out_last  <= r_res_last;
            r_out_trunc <= r_res_trunc;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid            = r_out_valid;
    assign m_axis_tdata             = r_out_value;
    assign m_axis_tuser[USER_PRIME] = r_out_prime;
    assign m_axis_tuser[USER_TRUNC] = r_out_trunc;
    assign m_axis_tlast             = r_out_last;

endmodule

FILE: hdl/tdpe_rem_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module tdpe_rem_unit
    import tdpe_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output t_rem_stat               o_stat
);

    localparam int unsigned CW = $clog2(NUMBER_WIDTH);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [NUMBER_WIDTH-1:0] r_shift;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_div;

    logic [NUMBER_WIDTH:0]   w_trial;
    logic [NUMBER_WIDTH:0]   w_sub;
    logic                    w_ge;
    logic [NUMBER_WIDTH-1:0] n_rem;

    // partial remainder with the next dividend bit shifted in
    assign w_trial = {r_rem, r_shift[NUMBER_WIDTH-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_sub[NUMBER_WIDTH-1:0] : w_trial[NUMBER_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CW'(NUMBER_WIDTH - 1);
                r_shift <= i_dividend;
                r_rem   <= '0;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_shift <= r_shift << 1;
                r_cnt   <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

FILE: hdl/tdpe_prime_chk.sv
// primality sequencer: walks trial divisors through a single remainder unit
module tdpe_prime_chk
    import tdpe_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_cand,
    output t_chk_stat               o_stat
);

    localparam int unsigned SQ_W = NUMBER_WIDTH + 1;

    t_chk_state              r_state, n_state;
    logic [NUMBER_WIDTH-1:0] r_n, n_n;
    logic [NUMBER_WIDTH-1:0] r_d, n_d;
    logic [SQ_W-1:0]         r_sq, n_sq;
    logic                    r_done, n_done;
    logic                    r_prime, n_prime;

    logic                    w_rem_start;
    t_rem_stat               w_rem_stat;

    tdpe_rem_unit #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rem_start),
        .i_dividend(r_n),
        .i_divisor (r_d),
        .o_stat    (w_rem_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_done      = 1'b0;
        n_prime     = r_prime;
        w_rem_start = 1'b0;
        unique case (r_state)
            CK_IDLE: begin
                if (i_start) begin
                    n_n = i_cand;
                    if (i_cand < NUMBER_WIDTH'(SMALLEST_PRIME)) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_d     = NUMBER_WIDTH'(SMALLEST_PRIME);
                        n_sq    = SQ_W'(SMALLEST_PRIME * SMALLEST_PRIME);
                        n_state = CK_TEST;
                    end
                end
            end
            CK_TEST: begin
                // divisor must stay within half and within the square root
                if ((r_d <= (r_n >> 1)) && (r_sq <= {1'b0, r_n})) begin
                    w_rem_start = 1'b1;
                    n_state     = CK_WAIT;
                end else begin
                    n_done  = 1'b1;
                    n_prime = 1'b1;
                    n_state = CK_IDLE;
                end
            end
            CK_WAIT: begin
                if (w_rem_stat.done) begin
                    if (w_rem_stat.zero) begin
                        n_done  = 1'b1;
                        n_prime = 1'b0;
                        n_state = CK_IDLE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_d     = r_d + NUMBER_WIDTH'(1);
                        n_sq    = r_sq + {r_d, 1'b1};
                        n_state = CK_TEST;
                    end
                end
            end
            default: n_state = CK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CK_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_n     <= n_n;
            r_d     <= n_d;
            r_sq    <= n_sq;
            r_prime <= n_prime;
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.prime = r_prime;

endmodule
